// ===== rtl/vspfb_pkg.sv =====
package vspfb_pkg;

  localparam int MAX_STATES_DEF = 16;
  localparam int MAX_ORDER_DEF  = 8;

  localparam logic [4:0]  STATE_COUNT_RST = 5'd1;
  localparam logic [20:0] INTERVAL_RST    = 21'd1;
  localparam logic [30:0] SCALE_RST       = 31'd39071;

  // register indexes
  localparam logic [1:0] REG_STATE_COUNT = 2'd0;
  localparam logic [1:0] REG_INTERVAL    = 2'd1;
  localparam logic [1:0] REG_SCALE       = 2'd2;

  // operations
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_STEP   = 2'd1;
  localparam logic [1:0] OP_FORCE  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // table selects
  localparam logic [2:0] SEL_LOW    = 3'd0;
  localparam logic [2:0] SEL_HIGH   = 3'd1;
  localparam logic [2:0] SEL_UP     = 3'd2;
  localparam logic [2:0] SEL_DOWN   = 3'd3;
  localparam logic [2:0] SEL_ORDER  = 3'd4;
  localparam logic [2:0] SEL_COEF   = 3'd5;
  localparam logic [2:0] SEL_RSVD_A = 3'd6;
  localparam logic [2:0] SEL_RSVD_B = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD_UP,
    ST_CHK_UP,
    ST_CHK_DN,
    ST_RD_CUR,
    ST_CLAMP,
    ST_POW,
    ST_TERM,
    ST_ACC,
    ST_FACTOR,
    ST_FORCE,
    ST_DONE
  } state_t;

  // round a 32x32 signed Q16.16 product back to Q16.16, round half up, saturate
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] r;
    logic signed [47:0] q;
    begin
      r = p + 64'sd32768;
      q = r[63:16];
      if (q > 48'sh7FFFFFFF) qround = 32'sh7FFFFFFF;
      else if (q < -48'sh80000000) qround = 32'sh80000000;
      else qround = q[31:0];
    end
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    begin
      s = {a[31], a} + {b[31], b};
      if (s > 33'sh07FFFFFFF) sat_add = 32'sh7FFFFFFF;
      else if (s < -33'sh080000000) sat_add = 32'sh80000000;
      else sat_add = s[31:0];
    end
  endfunction

endpackage

// ===== rtl/virtual_state_polynomial_force_bias.sv =====
// Virtual-state force bias. A table write or an unused operation goes from accept
// straight to the result beat, and a force item makes one pass through the shared
// multiplier before the result beat. A step item reads the neighbor tables, runs
// the up and down checks, clamps, takes three steps per polynomial term (power,
// term, accumulate) and one for the scale. An interval above one adds a
// bit-serial remainder check first, and a step that makes no attempt skips the up
// and down checks. The block takes no new item until the result beat has been
// taken. Tables have no reset.
module virtual_state_polynomial_force_bias #(
  parameter int MAX_STATES = vspfb_pkg::MAX_STATES_DEF,
  parameter int MAX_ORDER  = vspfb_pkg::MAX_ORDER_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [2:0]         table_select,
  input  logic [3:0]         state_index,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] table_value,
  input  logic [31:0]        step_count,
  input  logic signed [31:0] lambda_value,
  input  logic signed [31:0] force_in,
  input  logic               force_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] bias_factor,
  output logic [3:0]         current_state,
  output logic               attempted,
  output logic               moved,
  output logic signed [31:0] force_out,
  output logic               last_out
);
  localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam int TERMS = MAX_ORDER + 1;
  localparam int CDEPTH = MAX_STATES * TERMS;
  localparam int CW = $clog2(CDEPTH);

  // configuration registers
  logic [4:0]  state_count;
  logic [20:0] transition_interval;
  logic [30:0] scale_constant;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count         <= vspfb_pkg::STATE_COUNT_RST;
      transition_interval <= vspfb_pkg::INTERVAL_RST;
      scale_constant      <= vspfb_pkg::SCALE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        vspfb_pkg::REG_STATE_COUNT: state_count <= pwdata[4:0];
        vspfb_pkg::REG_INTERVAL:    transition_interval <= pwdata[20:0];
        vspfb_pkg::REG_SCALE:       scale_constant <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vspfb_pkg::REG_STATE_COUNT: prdata = {27'd0, state_count};
      vspfb_pkg::REG_INTERVAL:    prdata = {11'd0, transition_interval};
      vspfb_pkg::REG_SCALE:       prdata = {1'b0, scale_constant};
      default:                    prdata = '0;
    endcase
  end

  // effective state count, 1..MAX_STATES
  logic [8:0] n_eff;
  always_comb begin
    if (state_count == 5'd0) n_eff = 9'd1;
    else if ({4'd0, state_count} > 9'(MAX_STATES)) n_eff = 9'(MAX_STATES);
    else n_eff = {4'd0, state_count};
  end

  // tables
  logic signed [31:0] low_mem  [MAX_STATES];
  logic signed [31:0] high_mem [MAX_STATES];
  logic signed [31:0] up_mem   [MAX_STATES];
  logic signed [31:0] dn_mem   [MAX_STATES];
  logic [OW-1:0]      ord_mem  [MAX_STATES];
  logic signed [31:0] coef_mem [CDEPTH];

  // item registers
  logic [1:0]         op;
  logic [2:0]         sel;
  logic [SW-1:0]      sidx;
  logic [3:0]         cidx;
  logic signed [31:0] tval;
  logic signed [31:0] lam;
  logic signed [31:0] fin;
  logic               flast;

  logic [SW-1:0]      act;
  logic signed [31:0] factor;
  logic               att_r, mov_r;

  vspfb_pkg::state_t st, st_next;

  // table read port (registered), address chosen by sequencer
  logic [SW-1:0]      rd_s;
  logic signed [31:0] rd_low, rd_high, rd_up, rd_dn;
  logic [OW-1:0]      rd_ord;
  logic [CW-1:0]      c_addr;
  logic signed [31:0] rd_coef;

  // polynomial working registers
  logic signed [31:0] x, pw, acc, term;
  logic [OW-1:0]      k;
  logic               rem_zero_r;

  // remainder unit
  logic mod_start, mod_done, mod_zero;
  vspfb_mod u_mod (
    .clk(clk), .rst(rst), .start(mod_start),
    .dividend(step_count), .divisor(transition_interval),
    .done(mod_done), .is_zero(mod_zero)
  );

  logic accept;
  assign in_ready = (st == vspfb_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign mod_start = accept && (operation == vspfb_pkg::OP_STEP) &&
                     (transition_interval > 21'd1);

  // shared multiplier
  logic signed [31:0] ma, mb, mq;
  logic signed [63:0] mprod;
  always_comb begin
    ma = pw;
    mb = x;
    case (st)
      vspfb_pkg::ST_TERM:   begin ma = rd_coef; mb = pw; end
      vspfb_pkg::ST_FACTOR: begin ma = {1'b0, scale_constant}; mb = acc; end
      vspfb_pkg::ST_FORCE:  begin ma = fin; mb = factor; end
      default: ;
    endcase
    mprod = 64'(ma) * 64'(mb);
    mq = vspfb_pkg::qround(mprod);
  end

  // neighbor move conditions
  logic [8:0] s_up9;
  logic       up_ok;
  assign s_up9 = {{(9-SW){1'b0}}, act} + 9'd1;
  assign up_ok = (s_up9 < n_eff) && (lam >= rd_low) && (lam <= rd_high);

  // next state
  always_comb begin
    st_next = st;
    case (st)
      vspfb_pkg::ST_IDLE:
        if (accept) begin
          case (operation)
            vspfb_pkg::OP_STEP:
              st_next = (transition_interval > 21'd1) ? vspfb_pkg::ST_MOD
                                                     : vspfb_pkg::ST_RD_UP;
            vspfb_pkg::OP_FORCE: st_next = vspfb_pkg::ST_FORCE;
            default:             st_next = vspfb_pkg::ST_DONE;
          endcase
        end
      vspfb_pkg::ST_MOD:    if (mod_done) st_next = vspfb_pkg::ST_RD_UP;
      vspfb_pkg::ST_RD_UP:  st_next = rem_zero_r ? vspfb_pkg::ST_CHK_UP
                                                 : vspfb_pkg::ST_RD_CUR;
      vspfb_pkg::ST_CHK_UP: st_next = vspfb_pkg::ST_CHK_DN;
      vspfb_pkg::ST_CHK_DN: st_next = vspfb_pkg::ST_RD_CUR;
      vspfb_pkg::ST_RD_CUR: st_next = vspfb_pkg::ST_CLAMP;
      vspfb_pkg::ST_CLAMP:  st_next = (rd_ord == '0) ? vspfb_pkg::ST_FACTOR
                                                     : vspfb_pkg::ST_POW;
      vspfb_pkg::ST_POW:    st_next = vspfb_pkg::ST_TERM;
      vspfb_pkg::ST_TERM:   st_next = vspfb_pkg::ST_ACC;
      vspfb_pkg::ST_ACC:    st_next = (k == rd_ord) ? vspfb_pkg::ST_FACTOR
                                                    : vspfb_pkg::ST_POW;
      vspfb_pkg::ST_FACTOR: st_next = vspfb_pkg::ST_DONE;
      vspfb_pkg::ST_FORCE:  st_next = vspfb_pkg::ST_DONE;
      vspfb_pkg::ST_DONE:   if (out_ready) st_next = vspfb_pkg::ST_IDLE;
      default:              st_next = vspfb_pkg::ST_IDLE;
    endcase
  end

  // read addresses: upper neighbor lands for the up check, lower for the down check
  always_comb begin
    rd_s   = act;
    c_addr = CW'(act * TERMS);
    case (st)
      vspfb_pkg::ST_RD_UP:
        rd_s = (s_up9 < 9'(MAX_STATES)) ? SW'(s_up9) : act;
      vspfb_pkg::ST_CHK_UP: rd_s = act - SW'(1);
      vspfb_pkg::ST_POW, vspfb_pkg::ST_TERM, vspfb_pkg::ST_ACC:
        c_addr = CW'(act * TERMS + k);
      default: ;
    endcase
  end

  // memories: write on a table write beat, registered reads
  always_ff @(posedge clk) begin
    if (st == vspfb_pkg::ST_DONE && op == vspfb_pkg::OP_WRITE && out_ready) begin
      case (sel)
        vspfb_pkg::SEL_LOW:  low_mem[sidx]  <= tval;
        vspfb_pkg::SEL_HIGH: high_mem[sidx] <= tval;
        vspfb_pkg::SEL_UP:   up_mem[sidx]   <= tval;
        vspfb_pkg::SEL_DOWN: dn_mem[sidx]   <= tval;
        vspfb_pkg::SEL_ORDER:
          ord_mem[sidx] <= tval[31] ? '0 :
                           (tval > 32'(MAX_ORDER)) ? OW'(MAX_ORDER) : OW'(tval);
        vspfb_pkg::SEL_COEF:
          if (cidx <= 4'(MAX_ORDER)) coef_mem[CW'(sidx * TERMS + cidx)] <= tval;
        default: ;
      endcase
    end
    rd_low  <= low_mem[rd_s];
    rd_high <= high_mem[rd_s];
    rd_up   <= up_mem[act];
    rd_dn   <= dn_mem[act];
    rd_ord  <= ord_mem[rd_s];
    rd_coef <= coef_mem[c_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= vspfb_pkg::ST_IDLE;
      act    <= '0;
      factor <= '0;
      att_r  <= 1'b0;
      mov_r  <= 1'b0;
      rem_zero_r <= 1'b0;
    end else begin
      st <= st_next;
      case (st)
        vspfb_pkg::ST_IDLE: if (accept) begin
          att_r <= 1'b0;
          mov_r <= 1'b0;
          rem_zero_r <= 1'b1;
        end
        vspfb_pkg::ST_MOD: if (mod_done) rem_zero_r <= mod_zero;
        vspfb_pkg::ST_RD_UP: att_r <= rem_zero_r;
        vspfb_pkg::ST_CHK_UP:
          if (up_ok && rd_up > 0) begin
            act <= SW'(s_up9);
            mov_r <= 1'b1;
          end
        vspfb_pkg::ST_CHK_DN:
          if (!mov_r && act != '0 && lam >= rd_low && lam <= rd_high && rd_dn > 0) begin
            act <= act - SW'(1);
            mov_r <= 1'b1;
          end
        vspfb_pkg::ST_FACTOR: factor <= mq;
        default: ;
      endcase
    end
  end

  // item capture and datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= operation;
      sel   <= table_select;
      sidx  <= SW'(state_index);
      cidx  <= coef_index;
      tval  <= table_value;
      lam   <= lambda_value;
      fin   <= force_in;
      flast <= force_last;
      term  <= '0;
    end
    case (st)
      vspfb_pkg::ST_CLAMP: begin
        if (lam <= rd_low) x <= rd_low;
        else if (lam >= rd_high) x <= rd_high;
        else x <= lam;
        pw  <= 32'sh00010000;
        acc <= rd_coef;
        k   <= OW'(1);
      end
      vspfb_pkg::ST_POW:   pw <= mq;
      vspfb_pkg::ST_TERM:  term <= mq;
      vspfb_pkg::ST_ACC: begin
        acc <= vspfb_pkg::sat_add(acc, term);
        k   <= k + OW'(1);
      end
      vspfb_pkg::ST_FORCE: term <= mq;
      default: ;
    endcase
  end

  // result beat
  assign out_valid     = (st == vspfb_pkg::ST_DONE);
  assign bias_factor   = factor;
  assign current_state = 4'(act);
  assign attempted     = (op == vspfb_pkg::OP_STEP) && att_r;
  assign moved         = (op == vspfb_pkg::OP_STEP) && mov_r;
  assign force_out     = (op == vspfb_pkg::OP_FORCE) ? term : '0;
  assign last_out      = (op == vspfb_pkg::OP_FORCE) && flast;
endmodule

// ===== rtl/vspfb_mod.sv =====
// Bit-serial remainder test: one quotient bit per cycle over the 32-bit dividend.
module vspfb_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [20:0] divisor,
  output logic        done,
  output logic        is_zero
);
  logic [31:0] quo;
  logic [21:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [21:0] trial;

  assign trial = {rem[20:0], quo[31]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[30:0], 1'b0};
      if (!trial[21]) rem <= trial;
      else rem <= {rem[20:0], quo[31]};
    end
  end

  assign is_zero = (rem == '0);
endmodule

// ===== tb/tb_virtual_state_polynomial_force_bias.sv =====
module tb_virtual_state_polynomial_force_bias;

  localparam int NSTATE    = 16;
  localparam int NORDER    = 8;
  localparam int LIMIT     = 3000000;
  localparam int TAIL_WAIT = 100;

  typedef struct {
    logic [1:0]         op;
    logic [2:0]         sel;
    logic [3:0]         si;
    logic [3:0]         ci;
    logic signed [31:0] tv;
    logic [31:0]        sc;
    logic signed [31:0] lam;
    logic signed [31:0] fin;
    logic               flast;
  } item_t;

  typedef struct {
    logic signed [31:0] factor;
    logic [3:0]         vstate;
    logic               att;
    logic               mov;
    logic signed [31:0] fout;
    logic               last;
  } beat_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic [1:0] operation;
  logic [2:0] table_select;
  logic [3:0] state_index, coef_index;
  logic signed [31:0] table_value, lambda_value, force_in;
  logic [31:0] step_count;
  logic force_last;
  logic out_valid, out_ready;
  logic signed [31:0] bias_factor, force_out;
  logic [3:0] current_state;
  logic attempted, moved, last_out;

  virtual_state_polynomial_force_bias u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .table_select(table_select),
    .state_index(state_index), .coef_index(coef_index),
    .table_value(table_value), .step_count(step_count),
    .lambda_value(lambda_value), .force_in(force_in), .force_last(force_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .bias_factor(bias_factor), .current_state(current_state),
    .attempted(attempted), .moved(moved), .force_out(force_out),
    .last_out(last_out)
  );

  // shadow of the block: tables, state and registers
  int          lo_tab [NSTATE];
  int          hi_tab [NSTATE];
  int          up_tab [NSTATE];
  int          dn_tab [NSTATE];
  int          ord_tab [NSTATE];
  int          coef_tab [NSTATE][NORDER+1];
  int unsigned act_state;
  int          factor_q;
  int unsigned cfg_count, cfg_interval, cfg_scale;

  item_t item_q[$];
  beat_t result_q[$];
  item_t cur;
  logic  in_taken;
  int    burst_left, gap_left, stall_left, stall_mode;
  int    errors, cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // Q16.16 product, round half up, saturate
  function automatic int qmul(longint a, longint b);
    longint p;
    p = a * b + 32768;
    return sat32(p >>> 16);
  endfunction

  function automatic bit lam_fits(int unsigned s, int lam);
    return lam >= lo_tab[s] && lam <= hi_tab[s];
  endfunction

  // clamp lambda, evaluate the active polynomial, scale it
  function automatic void update_factor(int lam);
    int unsigned s;
    int x, pw, acc;
    s = act_state;
    x = lam;
    if (lam <= lo_tab[s]) x = lo_tab[s];
    else if (lam >= hi_tab[s]) x = hi_tab[s];
    pw = 65536;
    acc = coef_tab[s][0];
    for (int i = 1; i <= ord_tab[s]; i++) begin
      pw = qmul(pw, x);
      acc = sat32(longint'(acc) + qmul(coef_tab[s][i], pw));
    end
    factor_q = qmul(longint'(cfg_scale), acc);
  endfunction

  function automatic beat_t predict_beat(item_t it);
    beat_t b;
    int unsigned iv, n, s;
    b.att = 1'b0; b.mov = 1'b0; b.fout = 0; b.last = 1'b0;
    case (it.op)
      vspfb_pkg::OP_WRITE: begin
        case (it.sel)
          vspfb_pkg::SEL_LOW:   lo_tab[it.si] = it.tv;
          vspfb_pkg::SEL_HIGH:  hi_tab[it.si] = it.tv;
          vspfb_pkg::SEL_UP:    up_tab[it.si] = it.tv;
          vspfb_pkg::SEL_DOWN:  dn_tab[it.si] = it.tv;
          vspfb_pkg::SEL_ORDER:
            ord_tab[it.si] = (it.tv < 0) ? 0 : ((it.tv > NORDER) ? NORDER : it.tv);
          vspfb_pkg::SEL_COEF:  if (it.ci <= NORDER) coef_tab[it.si][it.ci] = it.tv;
          default: ;
        endcase
      end
      vspfb_pkg::OP_STEP: begin
        iv = (cfg_interval == 0) ? 1 : cfg_interval;
        n = (cfg_count == 0) ? 1 : ((cfg_count > NSTATE) ? NSTATE : cfg_count);
        if (it.sc % iv == 0) begin
          s = act_state;
          b.att = 1'b1;
          if (s + 1 < n && lam_fits(s + 1, it.lam) && up_tab[s] > 0) begin
            act_state = s + 1;
            b.mov = 1'b1;
          end else if (s > 0 && lam_fits(s - 1, it.lam) && dn_tab[s] > 0) begin
            act_state = s - 1;
            b.mov = 1'b1;
          end
        end
        update_factor(it.lam);
      end
      vspfb_pkg::OP_FORCE: begin
        b.fout = qmul(it.fin, factor_q);
        b.last = it.flast;
      end
      default: ;
    endcase
    b.factor = factor_q;
    b.vstate = act_state[3:0];
    return b;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // input driver: bursts and gaps, payload changes on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        cur = item_q.pop_front();
        operation <= cur.op; table_select <= cur.sel; state_index <= cur.si;
        coef_index <= cur.ci; table_value <= cur.tv; step_count <= cur.sc;
        lambda_value <= cur.lam; force_in <= cur.fin; force_last <= cur.flast;
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // accept beats, predict, check results
  always @(posedge clk) begin
    beat_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("tb_virtual_state_polynomial_force_bias: FAIL");
      $finish;
    end
    in_taken <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) result_q.push_back(predict_beat(cur));
    if (!rst && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected beat", bias_factor, 0);
      end else begin
        want = result_q.pop_front();
        if (bias_factor !== want.factor) report_mismatch("bias_factor", bias_factor, want.factor);
        if (current_state !== want.vstate)
          report_mismatch("current_state", current_state, want.vstate);
        if (attempted !== want.att) report_mismatch("attempted", attempted, want.att);
        if (moved !== want.mov) report_mismatch("moved", moved, want.mov);
        if (force_out !== want.fout) report_mismatch("force_out", force_out, want.fout);
        if (last_out !== want.last) report_mismatch("last_out", last_out, want.last);
      end
    end
  end

  task automatic push_item(logic [1:0] op, logic [2:0] sel, logic [3:0] si, logic [3:0] ci,
                           logic [31:0] tv, logic [31:0] sc, logic [31:0] lam,
                           logic [31:0] fin, logic flast);
    item_t it;
    it.op = op; it.sel = sel; it.si = si; it.ci = ci; it.tv = tv;
    it.sc = sc; it.lam = lam; it.fin = fin; it.flast = flast;
    item_q.push_back(it);
  endtask

  // table write with random noise in the unused fields
  task automatic push_write(logic [2:0] sel, logic [3:0] si, logic [3:0] ci, logic [31:0] v);
    push_item(vspfb_pkg::OP_WRITE, sel, si, ci, v, $urandom, $urandom, $urandom,
              1'($urandom_range(0, 1)));
  endtask

  task automatic push_step(logic [31:0] sc, logic [31:0] lam);
    push_item(vspfb_pkg::OP_STEP, 3'($urandom), 4'($urandom), 4'($urandom), $urandom,
              sc, lam, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic push_force(logic [31:0] fin, logic flast);
    push_item(vspfb_pkg::OP_FORCE, 3'($urandom), 4'($urandom), 4'($urandom), $urandom,
              $urandom, $urandom, fin, flast);
  endtask

  function automatic int coef_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 0;
      default: return $signed($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic int prob_value();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return -$signed($urandom_range(1, 65536));
      2: return $urandom;
      default: return $urandom_range(1, 65536);
    endcase
  endfunction

  // load every table entry: overlapping lambda windows, a few inverted
  task automatic load_tables();
    int base, lo, hi;
    for (int s = 0; s < NSTATE; s++) begin
      base = s * 65536;
      lo = base - $urandom_range(0, 65536);
      hi = base + $urandom_range(32768, 98304);
      if ($urandom_range(0, 9) == 0) begin
        push_write(vspfb_pkg::SEL_LOW, 4'(s), 4'($urandom), hi);
        push_write(vspfb_pkg::SEL_HIGH, 4'(s), 4'($urandom), lo);
      end else begin
        push_write(vspfb_pkg::SEL_LOW, 4'(s), 4'($urandom), lo);
        push_write(vspfb_pkg::SEL_HIGH, 4'(s), 4'($urandom), hi);
      end
      push_write(vspfb_pkg::SEL_UP, 4'(s), 4'($urandom), prob_value());
      push_write(vspfb_pkg::SEL_DOWN, 4'(s), 4'($urandom), prob_value());
      push_write(vspfb_pkg::SEL_ORDER, 4'(s), 4'($urandom),
                 ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, NORDER));
      for (int c = 0; c <= NORDER; c++)
        push_write(vspfb_pkg::SEL_COEF, 4'(s), 4'(c), coef_value());
    end
  endtask

  function automatic logic [31:0] step_value();
    int unsigned iv;
    iv = (cfg_interval == 0) ? 1 : cfg_interval;
    if ($urandom_range(0, 3) == 0) return $urandom;
    return iv * $urandom_range(0, 4095);
  endfunction

  function automatic logic [31:0] lambda_pick();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $signed($urandom_range(0, 18 * 65536)) - 65536;
  endfunction

  // random mix: mostly forces, steps with mostly aligned counts, some unused operations and rewrites
  task automatic push_random(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        push_force($urandom, 1'($urandom_range(0, 1)));
      end else if (k < 85) begin
        push_step(step_value(), lambda_pick());
      end else if (k < 88) begin
        push_item(vspfb_pkg::OP_UNUSED, 3'($urandom), 4'($urandom), 4'($urandom),
                  $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end else if (k < 91) begin
        push_write(3'($urandom_range(6, 7)), 4'($urandom), 4'($urandom), $urandom);
      end else if (k < 93) begin
        push_write(vspfb_pkg::SEL_COEF, 4'($urandom), 4'($urandom_range(9, 15)), $urandom);
      end else begin
        push_write(3'($urandom_range(0, 5)), 4'($urandom), 4'($urandom_range(0, NORDER)),
                   ($urandom_range(0, 1) == 0) ? coef_value() : prob_value());
      end
    end
  endtask

  // wait for all beats to drain, then let the block settle
  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (item_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (TAIL_WAIT) @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      vspfb_pkg::REG_STATE_COUNT: cfg_count = value & 32'h1F;
      vspfb_pkg::REG_INTERVAL:    cfg_interval = value & 32'h1FFFFF;
      default:                    cfg_scale = value & 32'h7FFFFFFF;
    endcase
  endtask

  task automatic set_config(logic [31:0] n, logic [31:0] iv, logic [31:0] sc);
    drain();
    reg_write(vspfb_pkg::REG_STATE_COUNT, n);
    reg_write(vspfb_pkg::REG_INTERVAL, iv);
    reg_write(vspfb_pkg::REG_SCALE, sc);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; out_ready = 1'b0;
    operation = '0; table_select = '0; state_index = '0; coef_index = '0;
    table_value = '0; step_count = '0; lambda_value = '0; force_in = '0;
    force_last = 1'b0; in_taken = 1'b0;
    burst_left = 0; gap_left = 0; stall_left = 0; stall_mode = 0;
    errors = 0; cycles = 0;
    act_state = 0; factor_q = 0;
    cfg_count = 32'(vspfb_pkg::STATE_COUNT_RST);
    cfg_interval = 32'(vspfb_pkg::INTERVAL_RST);
    cfg_scale = 32'(vspfb_pkg::SCALE_RST);
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // reset values first, then directed corners
    load_tables();
    push_force(32'h7FFFFFFF, 1'b1);
    push_step(32'hFFFFFFFF, 32'h80000000);
    set_config(32'd16, 32'd1, 32'h7FFFFFFF);
    push_write(vspfb_pkg::SEL_RSVD_A, 4'd0, 4'd0, 32'h12345678);
    push_write(vspfb_pkg::SEL_RSVD_B, 4'd15, 4'd15, 32'h87654321);
    push_write(vspfb_pkg::SEL_COEF, 4'd3, 4'd15, 32'hFFFFFFFF);
    push_write(vspfb_pkg::SEL_ORDER, 4'd1, 4'd0, 32'hFFFFFFFF);
    push_write(vspfb_pkg::SEL_ORDER, 4'd2, 4'd0, 32'h7FFFFFFF);
    push_write(vspfb_pkg::SEL_UP, 4'd0, 4'd0, 32'd65536);
    push_write(vspfb_pkg::SEL_DOWN, 4'd1, 4'd0, 32'd65536);
    push_write(vspfb_pkg::SEL_LOW, 4'd1, 4'd0, 32'd0);
    push_write(vspfb_pkg::SEL_HIGH, 4'd1, 4'd0, 32'd131072);
    push_write(vspfb_pkg::SEL_LOW, 4'd0, 4'd0, 32'd65536);
    push_write(vspfb_pkg::SEL_HIGH, 4'd0, 4'd0, 32'd0);
    push_step(32'd0, 32'd65536);
    push_step(32'd0, 32'h7FFFFFFF);
    push_step(32'hFFFFFFFF, 32'h80000000);
    push_force(32'h80000000, 1'b0);
    push_force(32'h7FFFFFFF, 1'b1);
    push_force(32'h00000000, 1'b0);
    push_force(32'hFFFFFFFF, 1'b1);
    push_item(vspfb_pkg::OP_UNUSED, vspfb_pkg::SEL_RSVD_B, 4'd15, 4'd15, 32'hFFFFFFFF,
              32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    push_random(180);

    // register extremes and a spread of ordinary settings
    set_config(32'd0, 32'd0, 32'd0);
    push_random(100);
    set_config(32'd31, 32'd2, 32'd65536);
    load_tables();
    push_random(150);
    set_config(32'd5, 32'd1048576, $urandom_range(0, 32'h7FFFFFFF));
    push_random(100);
    set_config(32'h1F, 32'h1FFFFF, 32'h7FFFFFFF);
    push_random(120);
    set_config(32'd16, 32'd1, 32'd39071);
    load_tables();
    push_random(200);
    set_config($urandom_range(1, 16), $urandom_range(1, 3), $urandom_range(0, 200000));
    push_random(200);
    drain();

    if (errors == 0) $display("tb_virtual_state_polynomial_force_bias: PASS");
    else $display("tb_virtual_state_polynomial_force_bias: FAIL");
    $finish;
  end

endmodule
